// ===== hdl/crlfw_pkg.sv =====
// shared types and constants for the crlf expander with octet window
`default_nettype none
package crlfw_pkg;

	// octet codes
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SP = 8'h20;

	// configuration register indexes
	localparam int         CFG_IDX_W        = 2;
	localparam logic [1:0] REG_NEWS_MODE    = 2'd0;
	localparam logic [1:0] REG_MESSAGE_SIZE = 2'd1;
	localparam logic [1:0] REG_PARTIAL_START = 2'd2;
	localparam logic [1:0] REG_PARTIAL_COUNT = 2'd3;
	localparam int         CFG_DATA_W       = 32;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// one queued item: one or two result octets
	typedef struct packed {
		logic       two;        // CR goes out before last_byte
		logic [7:0] last_byte;  // final octet of this item
		logic       done;       // final octet uses up the length
	} entry_t;

endpackage
`default_nettype wire

// ===== hdl/crlfw_queue.sv =====
// short item queue between the classifying front and the output back
`default_nettype none
module crlfw_queue
	import crlfw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	input  wire logic   pop,
	output entry_t      head,
	output logic        not_empty
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// fill count stays in range and tracks the pointers
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== hdl/crlfw_front.sv =====
// front: config registers, window counters and item classification
`default_nettype none
module crlfw_front
	import crlfw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  op,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  first_item,
	input  wire logic                  q_full,
	output logic                       q_push,
	output entry_t                     q_entry
);

	logic        news_mode_q;
	logic [31:0] message_size_q;
	logic [31:0] partial_start_q;
	logic [31:0] partial_count_q;
	logic [31:0] skip_q;
	logic [31:0] bytes_q;

	logic        accept;
	logic [31:0] ld_skip;
	logic [31:0] ld_len;
	logic [31:0] base_len;
	logic [31:0] s_eff;
	logic [31:0] b_eff;
	logic        two_oct;
	logic [1:0]  n_oct;
	logic [1:0]  n_skip;
	logic [1:0]  n_cand;
	logic [1:0]  n_emit;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			news_mode_q     <= 1'b0;
			message_size_q  <= '0;
			partial_start_q <= '0;
			partial_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEWS_MODE:     news_mode_q     <= cfg_data[0];
				REG_MESSAGE_SIZE:  message_size_q  <= cfg_data;
				REG_PARTIAL_START: partial_start_q <= cfg_data;
				REG_PARTIAL_COUNT: partial_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter load values
	always_comb begin
		base_len = (message_size_q < partial_start_q) ? 32'd0
			: (message_size_q - partial_start_q + 32'd1);
		if (partial_start_q == '0) begin
			ld_skip = '0;
			ld_len  = message_size_q;
		end else begin
			ld_skip = partial_start_q - 32'd1;
			ld_len  = (base_len > partial_count_q) ? partial_count_q : base_len;
		end
	end

	// classify the item against the window
	always_comb begin
		s_eff   = first_item ? ld_skip : skip_q;
		b_eff   = first_item ? ld_len : bytes_q;
		two_oct = !op && news_mode_q && (data_byte == CHAR_LF);
		n_oct   = two_oct ? 2'd2 : 2'd1;
		// padding ignores the skip counter
		if (op || s_eff == '0) begin
			n_skip = 2'd0;
		end else if (two_oct && s_eff != 32'd1) begin
			n_skip = 2'd2;
		end else begin
			n_skip = 2'd1;
		end
		n_cand = n_oct - n_skip;
		if (b_eff == '0) begin
			n_emit = 2'd0;
		end else if (b_eff == 32'd1) begin
			n_emit = (n_cand != 2'd0) ? 2'd1 : 2'd0;
		end else begin
			n_emit = n_cand;
		end
	end

	// queue entry: last octet is LF for an expanded line end, or CR when the length ends after the CR
	always_comb begin
		q_push            = accept && (n_emit != 2'd0);
		q_entry.two       = (n_emit == 2'd2);
		q_entry.done      = (b_eff == {30'd0, n_emit});
		if (op) begin
			q_entry.last_byte = CHAR_SP;
		end else if (two_oct) begin
			q_entry.last_byte = (n_skip == 2'd0 && n_emit == 2'd1) ? CHAR_CR : CHAR_LF;
		end else begin
			q_entry.last_byte = data_byte;
		end
	end

	// window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			bytes_q <= '0;
		end else if (accept) begin
			skip_q  <= s_eff - {30'd0, n_skip};
			bytes_q <= b_eff - {30'd0, n_emit};
		end
	end

`ifndef SYNTHESIS
	// without a load the counters only run down
	a_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_item |=> skip_q <= $past(skip_q) && bytes_q <= $past(bytes_q))
		else $error("window counter grew without a load");
	// a section end leaves no length behind
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.done |=> bytes_q == '0)
		else $error("section end with length left");
`endif

endmodule
`default_nettype wire

// ===== hdl/crlfw_back.sv =====
// back: drains queued items into the registered result channel
`default_nettype none
module crlfw_back
	import crlfw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire entry_t head,
	input  wire logic   q_not_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        section_done
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       section_done_q;
	logic       phase_q;
	logic       load;
	logic       cr_first;

	assign load     = !out_valid_q || !out_stall;
	assign cr_first = head.two && !phase_q;
	assign q_pop    = load && q_not_empty && !cr_first;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_not_empty;
			if (q_not_empty) begin
				phase_q <= cr_first;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load && q_not_empty) begin
			if (cr_first) begin
				out_byte_q     <= CHAR_CR;
				run_end_q      <= 1'b0;
				section_done_q <= 1'b0;
			end else begin
				out_byte_q     <= head.last_byte;
				run_end_q      <= 1'b1;
				section_done_q <= head.done;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_end      = run_end_q;
	assign section_done = section_done_q;

`ifndef SYNTHESIS
	// the second half of a line end is still queued
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> q_not_empty && head.two)
		else $error("line end half without queued item");
`endif

endmodule
`default_nettype wire

// ===== hdl/crlf_expander_with_octet_window_top.sv =====
// top level of the crlf expander with octet window
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   op, data_byte, first_item
// out      output     out_valid/out_stall out_byte, run_end, section_done
// cfg      input      cfg_we              cfg_index, cfg_data
//
// one item is taken per cycle while not stalled; the front settles its window counters in that cycle
// results leave through one output register at one per cycle while out_stall is low, so an expanded
// line end holds the back while it sends the CR and then the LF, and a four-entry queue absorbs it
// first result of an item enters the queue when it is taken and then loads into the output register
// arst_n clears counters, config, queue and output valid; no clearing pass
// in_stall rises only when the queue is full; out_stall freezes the output register
`default_nettype none
module crlf_expander_with_octet_window_top
	import crlfw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  op,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  first_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic                       run_end,
	output logic                       section_done
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_not_empty;
	entry_t q_entry;
	entry_t q_head;

	// classify and count
	crlfw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.data_byte  (data_byte),
		.first_item (first_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	// decoupling queue
	crlfw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.not_empty  (q_not_empty)
	);

	// result output
	crlfw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_not_empty  (q_not_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_end      (run_end),
		.section_done (section_done)
	);

endmodule
`default_nettype wire
